// File: hw/rtl/msp_v2_sensor_frame_parser_top_macros.svh
// Assertion helpers shared by the parser blocks
`ifndef MSP_V2_SENSOR_FRAME_PARSER_TOP_MACROS_SVH
`define MSP_V2_SENSOR_FRAME_PARSER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset
`define MSP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define MSP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hw/rtl/msp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int PAY_KEEP    = 9;
    localparam int PAY_IDX_W   = $clog2(PAY_KEEP);

    localparam logic [15:0] CMD_RANGE     = 16'h1F01;
    localparam logic [15:0] CMD_FLOW      = 16'h1F02;
    localparam logic [15:0] MIN_RANGE_LEN = 16'd5;
    localparam logic [15:0] MIN_FLOW_LEN  = 16'd9;
    localparam logic [7:0]  CRC_POLY      = 8'hD5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_LT     = 8'h3C;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUAL_THR   = 2'd1;
    localparam logic [15:0] DIST_LIMIT_RST = 16'd5000;
    localparam logic [7:0]  QUAL_THR_RST   = 8'd0;

    typedef struct packed {
        logic [15:0]                cmd;
        logic [15:0]                len;
        logic [PAY_KEEP-1:0][7:0]   pay;
    } frame_t;

    typedef struct packed {
        logic at_crc;
        logic crc_fire;
    } pstat_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/msp_frame_fsm.sv
`timescale 1ns / 1ps
`default_nettype none

module msp_frame_fsm (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            accept,
    input  wire logic [7:0]      rx_byte,
    output msp_pkg::frame_t      frame,
    output msp_pkg::pstat_t      stat
);
    import msp_pkg::*;
    `include "msp_v2_sensor_frame_parser_top_macros.svh"

    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HDR_X   = 4'd1;
    localparam logic [3:0] PH_HDR_DIR = 4'd2;
    localparam logic [3:0] PH_FLAG    = 4'd3;
    localparam logic [3:0] PH_CMD_LO  = 4'd4;
    localparam logic [3:0] PH_CMD_HI  = 4'd5;
    localparam logic [3:0] PH_SIZE_LO = 4'd6;
    localparam logic [3:0] PH_SIZE_HI = 4'd7;
    localparam logic [3:0] PH_PAYLOAD = 4'd8;
    localparam logic [3:0] PH_CRC     = 4'd9;

    logic [3:0]                 phase_reg, phase_next;
    logic [7:0]                 crc_reg, crc_next;
    logic [15:0]                cmd_reg, cmd_next;
    logic [15:0]                len_reg, len_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic [PAY_KEEP-1:0][7:0]   pay_reg, pay_next;
    logic [IDX_W-1:0]           idx_inc;
    logic [7:0]                 crc_upd;

    assign idx_inc = idx_reg + 1'b1;
    assign crc_upd = crc8_step(crc_reg, rx_byte);

    always_comb
    begin
        phase_next = phase_reg;
        crc_next   = crc_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        pay_next   = pay_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HDR_X:
                begin
                    phase_next = (rx_byte == CH_X) ? PH_HDR_DIR : PH_IDLE;
                end
                PH_HDR_DIR:
                begin
                    if (rx_byte == CH_LT)
                    begin
                        crc_next   = 8'd0;
                        phase_next = PH_FLAG;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_FLAG:
                begin
                    crc_next   = crc_upd;
                    phase_next = PH_CMD_LO;
                end
                PH_CMD_LO:
                begin
                    cmd_next   = {8'd0, rx_byte};
                    crc_next   = crc_upd;
                    phase_next = PH_CMD_HI;
                end
                PH_CMD_HI:
                begin
                    cmd_next   = {rx_byte, cmd_reg[7:0]};
                    crc_next   = crc_upd;
                    phase_next = PH_SIZE_LO;
                end
                PH_SIZE_LO:
                begin
                    len_next   = {8'd0, rx_byte};
                    crc_next   = crc_upd;
                    phase_next = PH_SIZE_HI;
                end
                PH_SIZE_HI:
                begin
                    len_next = {rx_byte, len_reg[7:0]};
                    crc_next = crc_upd;
                    idx_next = '0;
                    if (len_next > 16'(MAX_PAYLOAD))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else if (len_next == 16'd0)
                    begin
                        phase_next = PH_CRC;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    // keep only the leading bytes that the decoder looks at
                    for (int k = 0; k < PAY_KEEP; k++)
                    begin
                        if (idx_reg == IDX_W'(k))
                        begin
                            pay_next[k] = rx_byte;
                        end
                    end
                    idx_next = idx_inc;
                    crc_next = crc_upd;
                    if ({{(16-IDX_W){1'b0}}, idx_inc} >= len_reg)
                    begin
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = (rx_byte == CH_DOLLAR) ? PH_HDR_X : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            crc_reg   <= 8'd0;
            cmd_reg   <= 16'd0;
            len_reg   <= 16'd0;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            crc_reg   <= crc_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pay_reg <= pay_next;
    end

    assign frame.cmd     = cmd_reg;
    assign frame.len     = len_reg;
    assign frame.pay     = pay_reg;
    assign stat.at_crc   = (phase_reg == PH_CRC);
    assign stat.crc_fire = accept && (phase_reg == PH_CRC) && (crc_reg == rx_byte);

    `MSP_ASSERT(a_oversize_abort,
        accept && (phase_reg == PH_SIZE_HI) &&
        ({rx_byte, len_reg[7:0]} > 16'(MAX_PAYLOAD)) |=> (phase_reg == PH_IDLE),
        "oversize frame not dropped")
    `MSP_ASSERT(a_idx_in_frame,
        (phase_reg == PH_PAYLOAD) |-> ({{(16-IDX_W){1'b0}}, idx_reg} < len_reg),
        "payload index past frame size")

endmodule

`default_nettype wire

// File: hw/rtl/msp_decode_out.sv
`timescale 1ns / 1ps
`default_nettype none

module msp_decode_out (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [msp_pkg::CFG_DAT_W-1:0]  cfg_wdata,
    input  wire msp_pkg::frame_t                frame,
    input  wire msp_pkg::pstat_t                stat,
    input  wire logic                           out_ready,
    output logic                                out_valid,
    output logic                                packet_kind,
    output logic [7:0]                          sensor_quality,
    output logic signed [31:0]                  distance_mm,
    output logic                                distance_ok,
    output logic signed [31:0]                  flow_dx,
    output logic signed [31:0]                  flow_dy,
    output logic                                quality_ok
);
    import msp_pkg::*;
    `include "msp_v2_sensor_frame_parser_top_macros.svh"

    logic [15:0]    limit_reg;
    logic [7:0]     thr_reg;
    logic           valid_reg, valid_next;
    logic           kind_reg;
    logic [7:0]     qual_reg;
    logic [31:0]    dist_reg, mx_reg, my_reg;
    logic           dok_reg, qok_reg;

    logic           is_range, is_flow, hit;
    logic [31:0]    word_a, word_b;

    assign word_a   = {frame.pay[4], frame.pay[3], frame.pay[2], frame.pay[1]};
    assign word_b   = {frame.pay[8], frame.pay[7], frame.pay[6], frame.pay[5]};
    assign is_range = (frame.cmd == CMD_RANGE) && (frame.len >= MIN_RANGE_LEN);
    assign is_flow  = (frame.cmd == CMD_FLOW) && (frame.len >= MIN_FLOW_LEN);
    assign hit      = stat.crc_fire && (is_range || is_flow);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= DIST_LIMIT_RST;
            thr_reg   <= QUAL_THR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DIST_LIMIT: limit_reg <= cfg_wdata;
                CFG_QUAL_THR:   thr_reg   <= cfg_wdata[7:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (valid_reg && out_ready)
        begin
            valid_next = 1'b0;
        end
        if (hit)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            kind_reg <= is_flow && !is_range;
            qual_reg <= frame.pay[0];
            if (is_range)
            begin
                dist_reg <= word_a;
                dok_reg  <= !word_a[31] && (word_a < {16'd0, limit_reg});
                mx_reg   <= 32'd0;
                my_reg   <= 32'd0;
                qok_reg  <= 1'b0;
            end
            else
            begin
                dist_reg <= 32'd0;
                dok_reg  <= 1'b0;
                mx_reg   <= word_a;
                my_reg   <= word_b;
                qok_reg  <= (frame.pay[0] > thr_reg);
            end
        end
    end

    assign out_valid      = valid_reg;
    assign packet_kind    = kind_reg;
    assign sensor_quality = qual_reg;
    assign distance_mm    = dist_reg;
    assign distance_ok    = dok_reg;
    assign flow_dx        = mx_reg;
    assign flow_dy        = my_reg;
    assign quality_ok     = qok_reg;

    `MSP_ASSERT(a_no_overwrite,
        valid_reg && !out_ready |-> !stat.crc_fire,
        "result overwritten while stalled")
    `MSP_ASSERT(a_flow_clean,
        valid_reg && kind_reg |-> !dok_reg && (dist_reg == 32'd0),
        "flow result carries distance")
    `MSP_ASSERT(a_range_clean,
        valid_reg && !kind_reg |-> !qok_reg && (mx_reg == 32'd0) && (my_reg == 32'd0),
        "range result carries motion")

endmodule

`default_nettype wire

// File: hw/rtl/msp_v2_sensor_frame_parser_top.sv
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------------------
//  input     | in_valid / in_ready  | rx_byte
//  result    | out_valid / out_ready| packet_kind, sensor_quality, distance_mm,
//            |                      | distance_ok, flow_dx, flow_dy, quality_ok
//  config    | cfg_we               | cfg_index, cfg_wdata
//
//  One byte per cycle while in_ready; results are registered off the CRC byte.
//  The phase register, CRC and first nine payload bytes are updated per byte.
//  in_ready drops only when the CRC byte is due and a result waits untaken.
//  Reset returns the parser to header hunting and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module msp_v2_sensor_frame_parser_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [7:0]                     rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                packet_kind,
    output logic [7:0]                          sensor_quality,
    output logic signed [31:0]                  distance_mm,
    output logic                                distance_ok,
    output logic signed [31:0]                  flow_dx,
    output logic signed [31:0]                  flow_dy,
    output logic                                quality_ok,
    input  wire logic                           cfg_we,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [msp_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
    import msp_pkg::*;

    frame_t frame;
    pstat_t stat;
    logic   accept;

    assign in_ready = !out_valid || out_ready || !stat.at_crc;
    assign accept   = in_valid && in_ready;

    msp_frame_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .frame   (frame),
        .stat    (stat)
    );

    msp_decode_out u_dec (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .frame          (frame),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .packet_kind    (packet_kind),
        .sensor_quality (sensor_quality),
        .distance_mm    (distance_mm),
        .distance_ok    (distance_ok),
        .flow_dx        (flow_dx),
        .flow_dy        (flow_dy),
        .quality_ok     (quality_ok)
    );

endmodule

`default_nettype wire
